// ===== rtl/tiv_pkg.sv =====
// tiv_pkg: shared types, constants and the tetrahedron corner table for the
// isosurface vertex block. No dependencies.
`timescale 1ns / 1ps
package tiv_pkg;

	localparam int GRID_SIDE   = 32;
	localparam int IDX_W       = 5;
	localparam int ADDR_W      = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE);
	localparam int STORE_DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int NUM_TETRA   = 6;
	localparam int NUM_PAIRS   = 6;
	localparam int NUM_EDGES   = NUM_TETRA * NUM_PAIRS;
	localparam int EDGE_W      = $clog2(NUM_EDGES);
	localparam int NUM_CORNERS = 8;
	localparam int CORNER_W    = $clog2(NUM_CORNERS);
	localparam int WORD_W      = 128;
	localparam int HALF_UNIT   = 32768;
	localparam int CENTRE_UNIT = (GRID_SIDE - 1) * HALF_UNIT;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W   = 2;
	localparam int QUO_W       = 33;

	localparam logic [CFG_IDX_W-1:0] CFG_POS_SCALE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_THRESHOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTERING_FACTOR = 2'd2;

	// corners as xyz offset bits: bit2 = x, bit1 = y, bit0 = z
	localparam logic [2:0] TETRA_CORNER [NUM_TETRA][4] = '{
		'{3'd0, 3'd6, 3'd7, 3'd3},
		'{3'd0, 3'd2, 3'd6, 3'd3},
		'{3'd0, 3'd1, 3'd7, 3'd3},
		'{3'd4, 3'd1, 3'd5, 3'd7},
		'{3'd4, 3'd0, 3'd6, 3'd7},
		'{3'd4, 3'd1, 3'd0, 3'd7}
	};
	localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
	localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

	typedef struct packed {
		logic               func;
		logic [4:0]         grid_x;
		logic [4:0]         grid_y;
		logic [4:0]         grid_z;
		logic signed [31:0] raw_pos_x;
		logic signed [31:0] raw_pos_y;
		logic signed [31:0] raw_pos_z;
		logic signed [31:0] raw_field;
	} in_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               none_found;
		logic               last;
	} out_t;

	typedef struct packed {
		logic [30:0]        pos_scale;
		logic signed [31:0] field_threshold;
		logic [3:0]         centering_factor;
	} cfg_t;

	typedef struct packed {
		logic             none;
		logic             both_zero;
		logic             last;
		logic [2:0][31:0] p1;
		logic [2:0]       dneg;
		logic [2:0][31:0] dmag;
		logic [31:0]      a1;
		logic [32:0]      den;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W:0] x,
		input logic [IDX_W:0] y, input logic [IDX_W:0] z);
		return ADDR_W'((int'(x) * GRID_SIDE + int'(y)) * GRID_SIDE + int'(z));
	endfunction

endpackage

// ===== rtl/tiv_ram.sv =====
// tiv_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
`timescale 1ns / 1ps
module tiv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tiv_fifo.sv =====
// tiv_fifo: short job queue between the classifying front and the
// interpolating back. Depends on tiv_pkg.
`timescale 1ns / 1ps
module tiv_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  tiv_pkg::job_t       push_job,
	input  logic                pop,
	output tiv_pkg::job_t       pop_job,
	output tiv_pkg::fifo_stat_t stat
);

	tiv_pkg::job_t                   mem_q [tiv_pkg::FIFO_DEPTH];
	logic [tiv_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [tiv_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [tiv_pkg::FIFO_PTR_W:0]    count_q;

	assign stat.full  = (count_q == (tiv_pkg::FIFO_PTR_W+1)'(tiv_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tiv_front.sv =====
// tiv_front: accepts words, stores loaded grid points, fetches cube corners
// and queues one job per crossing edge, or a none-found job. Depends on tiv_pkg and tiv_ram.
`timescale 1ns / 1ps
module tiv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tiv_pkg::in_t        in_word,
	output logic                in_stall,
	input  tiv_pkg::cfg_t       cfg,
	output logic                push,
	output tiv_pkg::job_t       push_job,
	input  tiv_pkg::fifo_stat_t fifo_stat
);

	typedef enum logic [6:0] {
		F_IDLE = 7'b0000001,
		F_LMUL = 7'b0000010,
		F_LWR  = 7'b0000100,
		F_RD   = 7'b0001000,
		F_SCAN = 7'b0010000,
		F_EDGE = 7'b0100000,
		F_NONE = 7'b1000000
	} fstate_t;

	fstate_t                       state_q;
	logic [3:0]                    cnt_q;
	logic [tiv_pkg::IDX_W-1:0]     gx_q, gy_q, gz_q;
	logic signed [31:0]            raw_q [3];
	logic [31:0]                   fld_q;
	logic signed [65:0]            prod_q;
	logic [31:0]                   pos_q [3];
	logic [2:0]                    tet_q;
	logic [2:0]                    pair_q;
	logic                          rd_valid_q;
	logic [tiv_pkg::CORNER_W-1:0]  rd_corner_q;
	logic [31:0]                   corner_f_q [tiv_pkg::NUM_CORNERS];

	logic                          accept;
	logic [tiv_pkg::WORD_W-1:0]    big_rdata, sa_rdata, sb_rdata;
	logic [tiv_pkg::ADDR_W-1:0]    big_raddr, big_waddr;
	logic [2:0]                    ca, cb;
	logic signed [33:0]            diff;
	logic [33:0]                   centre;
	logic signed [65:0]            prod;
	logic [65:0]                   mag;
	logic [65:0]                   rsum;
	logic [49:0]                   rnd;
	logic [31:0]                   rounded;
	logic [32:0]                   fsub;
	logic [31:0]                   fsat;
	logic [tiv_pkg::NUM_EDGES-1:0] xing;
	logic [tiv_pkg::NUM_EDGES-1:0] later;
	logic [tiv_pkg::EDGE_W-1:0]    e_idx;
	logic                          last_edge;
	logic [2:0]                    cx;
	tiv_pkg::job_t                 edge_job;
	tiv_pkg::job_t                 none_job;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != F_IDLE);

	// load arithmetic: center, scale, round half away, saturate
	assign centre = 34'(cfg.centering_factor) * 34'(tiv_pkg::CENTRE_UNIT);
	assign diff   = {{2{raw_q[cnt_q[1:0]][31]}}, raw_q[cnt_q[1:0]]} - $signed(centre);
	assign prod   = diff * $signed({1'b0, cfg.pos_scale});
	assign mag    = prod_q[65] ? 66'(-prod_q) : 66'(prod_q);
	assign rsum   = mag + 66'(tiv_pkg::HALF_UNIT);
	assign rnd    = rsum[65:16];

	always_comb begin
		if (!prod_q[65]) begin
			rounded = (rnd > 50'h7FFFFFFF) ? 32'h7FFFFFFF : rnd[31:0];
		end else begin
			rounded = (rnd > 50'h80000000) ? 32'h80000000 : 32'(-rnd[31:0]);
		end
	end

	assign fsub = {in_word.raw_field[31], in_word.raw_field}
		- {cfg.field_threshold[31], cfg.field_threshold};
	assign fsat = (fsub[32] != fsub[31]) ? (fsub[32] ? 32'h80000000 : 32'h7FFFFFFF)
		: fsub[31:0];

	// crossing mask over all 36 tetrahedron edges
	always_comb begin
		for (int t = 0; t < tiv_pkg::NUM_TETRA; t++) begin
			for (int k = 0; k < tiv_pkg::NUM_PAIRS; k++) begin
				logic [31:0] fa, fb;
				fa = corner_f_q[tiv_pkg::TETRA_CORNER[t][tiv_pkg::PAIR_A[k]]];
				fb = corner_f_q[tiv_pkg::TETRA_CORNER[t][tiv_pkg::PAIR_B[k]]];
				xing[t * tiv_pkg::NUM_PAIRS + k] =
					((fa[31] || fa == '0) && !fb[31]) || (!fa[31] && (fb[31] || fb == '0));
			end
		end
	end

	assign e_idx = tiv_pkg::EDGE_W'(tet_q) * tiv_pkg::EDGE_W'(tiv_pkg::NUM_PAIRS)
		+ tiv_pkg::EDGE_W'(pair_q);

	always_comb begin
		for (int i = 0; i < tiv_pkg::NUM_EDGES; i++) begin
			later[i] = (i > int'(e_idx));
		end
	end
	assign last_edge = ((xing & later) == '0);

	assign ca = tiv_pkg::TETRA_CORNER[tet_q][tiv_pkg::PAIR_A[pair_q]];
	assign cb = tiv_pkg::TETRA_CORNER[tet_q][tiv_pkg::PAIR_B[pair_q]];

	// job for the current edge, from the two corner buffers
	always_comb begin
		logic [31:0] fa, fb;
		logic [31:0] a1, b1;
		logic [32:0] d;
		fa = sa_rdata[31:0];
		fb = sb_rdata[31:0];
		a1 = fa[31] ? 32'(-fa) : fa;
		b1 = fb[31] ? 32'(-fb) : fb;
		edge_job           = '0;
		edge_job.none      = 1'b0;
		edge_job.both_zero = (fa == '0) && (fb == '0);
		edge_job.last      = last_edge;
		edge_job.a1        = a1;
		edge_job.den       = {1'b0, a1} + {1'b0, b1};
		for (int c = 0; c < 3; c++) begin
			edge_job.p1[c] = sa_rdata[127 - 32 * c -: 32];
			d = {sb_rdata[127 - 32 * c], sb_rdata[127 - 32 * c -: 32]}
				- {sa_rdata[127 - 32 * c], sa_rdata[127 - 32 * c -: 32]};
			edge_job.dneg[c] = d[32];
			edge_job.dmag[c] = d[32] ? 32'(-d) : d[31:0];
		end
	end

	always_comb begin
		none_job      = '0;
		none_job.none = 1'b1;
		none_job.last = 1'b1;
	end

	always_comb begin
		push     = 1'b0;
		push_job = edge_job;
		case (state_q)
			F_EDGE: begin
				push = !fifo_stat.full;
			end
			F_NONE: begin
				push     = !fifo_stat.full;
				push_job = none_job;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	assign cx        = cnt_q[2:0];
	assign big_raddr = tiv_pkg::grid_addr({1'b0, gx_q} + {5'd0, cx[2]},
		{1'b0, gy_q} + {5'd0, cx[1]}, {1'b0, gz_q} + {5'd0, cx[0]});
	assign big_waddr = tiv_pkg::grid_addr({1'b0, gx_q}, {1'b0, gy_q}, {1'b0, gz_q});

	tiv_ram #(.WIDTH(tiv_pkg::WORD_W), .DEPTH(tiv_pkg::STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (state_q == F_LWR),
		.waddr (big_waddr),
		.wdata ({pos_q[0], pos_q[1], pos_q[2], fld_q}),
		.raddr (big_raddr),
		.rdata (big_rdata)
	);

	tiv_ram #(.WIDTH(tiv_pkg::WORD_W), .DEPTH(tiv_pkg::NUM_CORNERS)) u_corner_a (
		.clk   (clk),
		.we    (rd_valid_q),
		.waddr (rd_corner_q),
		.wdata (big_rdata),
		.raddr (ca),
		.rdata (sa_rdata)
	);

	tiv_ram #(.WIDTH(tiv_pkg::WORD_W), .DEPTH(tiv_pkg::NUM_CORNERS)) u_corner_b (
		.clk   (clk),
		.we    (rd_valid_q),
		.waddr (rd_corner_q),
		.wdata (big_rdata),
		.raddr (cb),
		.rdata (sb_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			gx_q     <= in_word.grid_x;
			gy_q     <= in_word.grid_y;
			gz_q     <= in_word.grid_z;
			raw_q[0] <= in_word.raw_pos_x;
			raw_q[1] <= in_word.raw_pos_y;
			raw_q[2] <= in_word.raw_pos_z;
			fld_q    <= fsat;
		end
		if (state_q == F_LMUL) begin
			if (cnt_q < 4'd3) begin
				prod_q <= prod;
			end
			if (cnt_q != 4'd0) begin
				pos_q[cnt_q[1:0] - 2'd1] <= rounded;
			end
		end
		if (rd_valid_q) begin
			corner_f_q[rd_corner_q] <= big_rdata[31:0];
		end
		rd_corner_q <= cx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			cnt_q      <= '0;
			tet_q      <= '0;
			pair_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= (state_q == F_RD) && (cnt_q < 4'd8);
			case (state_q)
				F_IDLE: begin
					cnt_q  <= '0;
					tet_q  <= '0;
					pair_q <= '0;
					if (accept) begin
						if (!in_word.func) begin
							if (int'(in_word.grid_x) < tiv_pkg::GRID_SIDE
								&& int'(in_word.grid_y) < tiv_pkg::GRID_SIDE
								&& int'(in_word.grid_z) < tiv_pkg::GRID_SIDE) begin
								state_q <= F_LMUL;
							end
						end else if (int'(in_word.grid_x) + 1 < tiv_pkg::GRID_SIDE
							&& int'(in_word.grid_y) + 1 < tiv_pkg::GRID_SIDE
							&& int'(in_word.grid_z) + 1 < tiv_pkg::GRID_SIDE) begin
							state_q <= F_RD;
						end else begin
							state_q <= F_NONE;
						end
					end
				end
				F_LMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd3) begin
						state_q <= F_LWR;
					end
				end
				F_LWR: begin
					state_q <= F_IDLE;
				end
				F_RD: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd8) begin
						state_q <= F_SCAN;
					end
				end
				F_SCAN: begin
					if (xing == '0) begin
						state_q <= F_NONE;
					end else if (xing[e_idx]) begin
						state_q <= F_EDGE;
					end else if (pair_q == 3'(tiv_pkg::NUM_PAIRS - 1)) begin
						pair_q <= '0;
						tet_q  <= tet_q + 1'b1;
					end else begin
						pair_q <= pair_q + 1'b1;
					end
				end
				F_EDGE: begin
					if (!fifo_stat.full) begin
						if (last_edge) begin
							state_q <= F_IDLE;
						end else begin
							state_q <= F_SCAN;
							if (pair_q == 3'(tiv_pkg::NUM_PAIRS - 1)) begin
								pair_q <= '0;
								tet_q  <= tet_q + 1'b1;
							end else begin
								pair_q <= pair_q + 1'b1;
							end
						end
					end
				end
				F_NONE: begin
					if (!fifo_stat.full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/tiv_back.sv =====
// tiv_back: takes queued edge jobs, interpolates the crossing vertex with a
// shared multiplier and a bit-serial divider, and holds the result word.
// Depends on tiv_pkg.
`timescale 1ns / 1ps
module tiv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  tiv_pkg::job_t       pop_job,
	input  tiv_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	output logic                out_valid,
	output tiv_pkg::out_t       out_word,
	input  logic                out_stall
);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_MUL  = 4'b0010,
		B_DIV  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t                     state_q;
	logic [5:0]                  cnt_q;
	tiv_pkg::job_t               job_q;
	logic [63:0]                 prod_q [3];
	logic [32:0]                 num_q  [3];
	logic [32:0]                 rem_q  [3];
	logic [tiv_pkg::QUO_W-1:0]   quo_q  [3];
	logic                        ovalid_q;
	tiv_pkg::out_t               out_q;

	logic                        load_out;
	tiv_pkg::out_t               result;

	assign pop       = (state_q == B_IDLE) && !fifo_stat.empty;
	assign load_out  = (state_q == B_OUT) && (!ovalid_q || !out_stall);
	assign out_valid = ovalid_q;
	assign out_word  = out_q;

	always_comb begin
		logic [31:0] v [3];
		for (int c = 0; c < 3; c++) begin
			if (job_q.none) begin
				v[c] = '0;
			end else if (job_q.both_zero) begin
				v[c] = job_q.p1[c];
			end else if (job_q.dneg[c]) begin
				v[c] = job_q.p1[c] - quo_q[c][31:0];
			end else begin
				v[c] = job_q.p1[c] + quo_q[c][31:0];
			end
		end
		result.vertex_x   = v[0];
		result.vertex_y   = v[1];
		result.vertex_z   = v[2];
		result.none_found = job_q.none;
		result.last       = job_q.last;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (state_q == B_MUL) begin
			if (cnt_q < 6'd3) begin
				prod_q[cnt_q[1:0]] <= 64'(job_q.dmag[cnt_q[1:0]]) * 64'(job_q.a1);
			end else begin
				// numerator plus half the denominator; upper part seeds the remainder
				for (int c = 0; c < 3; c++) begin
					logic [64:0] n;
					n = {1'b0, prod_q[c]} + 65'(job_q.den >> 1);
					rem_q[c] <= {1'b0, n[64:33]};
					num_q[c] <= n[32:0];
					quo_q[c] <= '0;
				end
			end
		end
		if (state_q == B_DIV) begin
			for (int c = 0; c < 3; c++) begin
				logic [33:0] t;
				logic        ge;
				t  = {rem_q[c], num_q[c][32]};
				ge = (t >= {1'b0, job_q.den});
				rem_q[c] <= ge ? 33'(t - {1'b0, job_q.den}) : t[32:0];
				num_q[c] <= {num_q[c][31:0], 1'b0};
				quo_q[c] <= {quo_q[c][tiv_pkg::QUO_W-2:0], ge};
			end
		end
		if (load_out) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						state_q <= (pop_job.none || pop_job.both_zero) ? B_OUT : B_MUL;
					end
				end
				B_MUL: begin
					if (cnt_q == 6'd3) begin
						cnt_q   <= '0;
						state_q <= B_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(tiv_pkg::QUO_W - 1)) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/tetra_isosurface_vertices_top.sv =====
// tetra_isosurface_vertices_top: marching tetrahedra vertex finder, top level
// with configuration registers. Depends on tiv_pkg, tiv_front, tiv_fifo, tiv_back.
`timescale 1ns / 1ps
// A load word stores one grid point (centered, scaled position and field
// minus threshold) in the front. A cube word fetches its eight corners from
// the grid store over its single read port, then scans the 36 tetrahedron
// edges, queueing one job per crossing edge (a "none found" job if none
// crosses or the cube is off the grid), and waits while the queue is full.
// The back finishes an interpolated vertex through a pop step, multiply
// steps on one shared 32x32 multiplier and a rounding seed step, 33 divide
// steps of the bit-serial divider, and an output step, and a "none found" or
// both-fields-zero result through the pop and output steps only; the back
// takes no new job until its last result is out. A 4-entry job queue sits
// between the two halves, and the result word is held in an output register
// so the back keeps working while a finished word waits.
module tetra_isosurface_vertices_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tiv_pkg::in_t                    in_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tiv_pkg::out_t                   out_word,
	input  logic                            cfg_we,
	input  logic [tiv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data
);

	tiv_pkg::cfg_t       cfg_q;
	logic                push, pop;
	tiv_pkg::job_t       push_job, pop_job;
	tiv_pkg::fifo_stat_t fifo_stat;

	// configuration registers; writes to an unused index drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_scale        <= 31'd65536;
			cfg_q.field_threshold  <= '0;
			cfg_q.centering_factor <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				tiv_pkg::CFG_POS_SCALE: begin
					cfg_q.pos_scale <= cfg_data[30:0];
				end
				tiv_pkg::CFG_FIELD_THRESHOLD: begin
					cfg_q.field_threshold <= cfg_data;
				end
				tiv_pkg::CFG_CENTERING_FACTOR: begin
					cfg_q.centering_factor <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	tiv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_word   (in_word),
		.in_stall  (in_stall),
		.cfg       (cfg_q),
		.push      (push),
		.push_job  (push_job),
		.fifo_stat (fifo_stat)
	);

	tiv_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.stat     (fifo_stat)
	);

	tiv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_job   (pop_job),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_word  (out_word),
		.out_stall (out_stall)
	);

endmodule

// ===== rtl/tiv_checker.sv =====
// tiv_checker: port-level assertions for the top level, attached by bind.
// Depends on tiv_pkg.
`timescale 1ns / 1ps
module tiv_sva (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input tiv_pkg::in_t  in_word,
	input logic          out_valid,
	input logic          out_stall,
	input tiv_pkg::out_t out_word
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	a_none_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.none_found |-> out_word.last)
		else $error("none_found word not marked last");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.none_found |->
		out_word.vertex_x == '0 && out_word.vertex_y == '0 && out_word.vertex_z == '0)
		else $error("none_found word carries a vertex");

	a_cube_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_word.func |=> in_stall)
		else $error("cube word did not hold off input");

endmodule

bind tetra_isosurface_vertices_top tiv_sva u_tiv_sva (.*);
